// ----- hw/rtl/ddhsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ddhsc_pkg: shared types and constants of the heading stepper controller
// register map, reset values, action codes, sequencer op codes, fsm type
// ----------------------------------------------------------------------------
package ddhsc_pkg;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PERIOD_SLOW   = 3'd0;
  localparam logic [2:0] REG_PERIOD_FAST   = 3'd1;
  localparam logic [2:0] REG_STEPS_PER_MOVE = 3'd2;
  localparam logic [2:0] REG_DEADBAND      = 3'd3;
  localparam logic [2:0] REG_ALIGN_COS     = 3'd4;
  localparam logic [2:0] REG_INV_MAX_SPEED = 3'd5;
  localparam logic [2:0] REG_ROT_COS       = 3'd6;
  localparam logic [2:0] REG_ROT_SIN       = 3'd7;

  // register reset values
  localparam logic [15:0] RST_PERIOD_SLOW    = 16'd35000;
  localparam logic [15:0] RST_PERIOD_FAST    = 16'd30000;
  localparam logic [9:0]  RST_STEPS_PER_MOVE = 10'd50;
  localparam logic [14:0] RST_DEADBAND       = 15'd328;
  localparam logic [14:0] RST_ALIGN_COS      = 15'd16056;
  localparam logic [15:0] RST_INV_MAX_SPEED  = 16'd10240;
  localparam logic [15:0] RST_ROT_COS        = 16'd16266;
  localparam logic [15:0] RST_ROT_SIN        = 16'd1961;

  // heading after reset: (0, -1.0) in Q2.14
  localparam logic [15:0] RST_HEADING_X = 16'h0000;
  localparam logic [15:0] RST_HEADING_Y = 16'hC000;

  // Q.14 levels
  localparam logic [14:0] Q14_ONE  = 15'd16384;
  localparam logic [14:0] Q14_HALF = 15'd8192;

  // result action codes
  typedef enum logic [1:0] {
    ACT_HOLD    = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_DISABLE = 2'd2
  } action_t;

  // sequencer fsm
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // sequencer op codes, one multiply issued per step
  localparam logic [4:0] OP_HXDX  = 5'd0;   // hx * dx
  localparam logic [4:0] OP_HYDY  = 5'd1;   // hy * dy
  localparam logic [4:0] OP_HXDY  = 5'd2;   // hx * dy
  localparam logic [4:0] OP_HYDX  = 5'd3;   // hy * dx
  localparam logic [4:0] OP_HXHX  = 5'd4;   // hx * hx
  localparam logic [4:0] OP_HYHY  = 5'd5;   // hy * hy
  localparam logic [4:0] OP_DXDX  = 5'd6;   // dx * dx
  localparam logic [4:0] OP_DYDY  = 5'd7;   // dy * dy
  localparam logic [4:0] OP_ACAC  = 5'd8;   // align_cos squared
  localparam logic [4:0] OP_DOT2  = 5'd9;   // dot squared
  localparam logic [4:0] OP_A2H2  = 5'd10;  // a2 * h2
  localparam logic [4:0] OP_SPIM  = 5'd11;  // speed * inv_max_speed
  localparam logic [4:0] OP_LOD2  = 5'd12;  // low half of a2h2 * d2
  localparam logic [4:0] OP_HID2  = 5'd13;  // high half of a2h2 * d2
  localparam logic [4:0] OP_HXC   = 5'd14;  // hx * cos
  localparam logic [4:0] OP_HYSN  = 5'd15;  // hy * signed sin
  localparam logic [4:0] OP_HXSN  = 5'd16;  // hx * signed sin
  localparam logic [4:0] OP_HYC   = 5'd17;  // hy * cos
  localparam logic [4:0] OP_MAD   = 5'd18;  // level * period span
  localparam logic [4:0] OP_FLUSH = 5'd19;  // drain last product
  localparam logic [4:0] OP_LAST  = OP_FLUSH;

endpackage

// ----- hw/rtl/diff_drive_heading_stepper_ctrl.sv -----
// ----------------------------------------------------------------------------
// diff_drive_heading_stepper_ctrl: heading controller for two stepper wheels
//
// in_ channel: one beat per control frame (desired x/y, speed, steps_done).
// out_ channel: one result beat per frame (action, signed steps and periods
// for both wheels, heading after the frame).
// apb port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the eight
// settings at byte addresses 0..28; write only while no frame is in flight.
// Each frame runs as sequencer steps through the one shared 33x33 multiplier,
// which computes every product of the frame one after another. in_ready is
// high only while idle, so a new frame waits until the last one is done.
// The result sits in an output register, so the next frame is accepted while
// the previous result still waits; if the receiver stalls past the end of
// the next computation, the sequencer holds in its done state.
// Reset (synchronous, rst_n low) loads the default settings and the heading
// (0, -1.0), and empties the output register.
// ----------------------------------------------------------------------------
module diff_drive_heading_stepper_ctrl
  import ddhsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_desired_x,
  input  logic [15:0] in_desired_y,
  input  logic [15:0] in_speed_cmd,
  input  logic        in_steps_done,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic [10:0] out_left_steps,
  output logic [10:0] out_right_steps,
  output logic [15:0] out_left_period,
  output logic [15:0] out_right_period,
  output logic [15:0] out_heading_x_out,
  output logic [15:0] out_heading_y_out,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // settings
  logic [15:0] period_slow_r, period_fast_r, inv_max_speed_r, rot_cos_r, rot_sin_r;
  logic [9:0]  steps_per_move_r;
  logic [14:0] deadband_r, align_cos_r;

  // control
  state_t      state_r;
  logic [4:0]  step_r;
  logic [4:0]  wb_step_r;
  logic        wb_vld_r;
  logic [15:0] hx_r, hy_r;

  // latched frame
  logic [15:0] dx_r, dy_r, sp_r;
  logic        done_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] prod_r;

  // intermediate results
  logic signed [32:0] dot_r, crs_r, nx_r, ny_r;
  logic [31:0] h2_r, d2_r;
  logic [29:0] a2_r;
  logic [62:0] dot2_r;
  logic [61:0] a2h2_r;
  logic signed [31:0] sprod_r;
  logic [93:0] rhs_r;
  logic [15:0] q_r;
  logic [14:0] m_r;
  logic        turn_r, left_pos_r, right_pos_r;

  // output register
  logic        out_valid_r;
  action_t     action_r;
  logic [10:0] lsteps_r, rsteps_r;
  logic [15:0] lper_r, rper_r;

  logic        cfg_wr;
  logic        in_fire;
  logic        out_load;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire = in_valid & in_ready;
  assign out_load = (state_r == ST_DONE) & (~out_valid_r | out_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_slow_r    <= RST_PERIOD_SLOW;
      period_fast_r    <= RST_PERIOD_FAST;
      steps_per_move_r <= RST_STEPS_PER_MOVE;
      deadband_r       <= RST_DEADBAND;
      align_cos_r      <= RST_ALIGN_COS;
      inv_max_speed_r  <= RST_INV_MAX_SPEED;
      rot_cos_r        <= RST_ROT_COS;
      rot_sin_r        <= RST_ROT_SIN;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_PERIOD_SLOW:    period_slow_r    <= pwdata[15:0];
        REG_PERIOD_FAST:    period_fast_r    <= pwdata[15:0];
        REG_STEPS_PER_MOVE: steps_per_move_r <= pwdata[9:0];
        REG_DEADBAND:       deadband_r       <= pwdata[14:0];
        REG_ALIGN_COS:      align_cos_r      <= pwdata[14:0];
        REG_INV_MAX_SPEED:  inv_max_speed_r  <= pwdata[15:0];
        REG_ROT_COS:        rot_cos_r        <= pwdata[15:0];
        REG_ROT_SIN:        rot_sin_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_PERIOD_SLOW:    prdata = {16'd0, period_slow_r};
      REG_PERIOD_FAST:    prdata = {16'd0, period_fast_r};
      REG_STEPS_PER_MOVE: prdata = {22'd0, steps_per_move_r};
      REG_DEADBAND:       prdata = {17'd0, deadband_r};
      REG_ALIGN_COS:      prdata = {17'd0, align_cos_r};
      REG_INV_MAX_SPEED:  prdata = {16'd0, inv_max_speed_r};
      REG_ROT_COS:        prdata = {16'd0, rot_cos_r};
      REG_ROT_SIN:        prdata = {16'd0, rot_sin_r};
      default:            prdata = 32'd0;
    endcase
  end

  // sign-extended operands
  logic signed [32:0] hx_e, hy_e, dx_e, dy_e, sp_e, cos_e, sin_e, sn_e;
  logic               crs_pos;
  logic [15:0]        span;
  logic               slow_ge;

  assign hx_e  = {{17{hx_r[15]}}, hx_r};
  assign hy_e  = {{17{hy_r[15]}}, hy_r};
  assign dx_e  = {{17{dx_r[15]}}, dx_r};
  assign dy_e  = {{17{dy_r[15]}}, dy_r};
  assign sp_e  = {{17{sp_r[15]}}, sp_r};
  assign cos_e = {{17{rot_cos_r[15]}}, rot_cos_r};
  assign sin_e = {{17{rot_sin_r[15]}}, rot_sin_r};
  assign crs_pos = ~crs_r[32] & (crs_r != 33'sd0);
  // turning left (cross positive) rotates by +sin, otherwise by -sin
  assign sn_e  = crs_pos ? sin_e : -sin_e;
  assign slow_ge = (period_slow_r >= period_fast_r);
  assign span  = slow_ge ? (period_slow_r - period_fast_r) : (period_fast_r - period_slow_r);

  // multiplier operand select
  always_comb begin
    case (step_r)
      OP_HXDX: begin mul_a = hx_e; mul_b = dx_e; end
      OP_HYDY: begin mul_a = hy_e; mul_b = dy_e; end
      OP_HXDY: begin mul_a = hx_e; mul_b = dy_e; end
      OP_HYDX: begin mul_a = hy_e; mul_b = dx_e; end
      OP_HXHX: begin mul_a = hx_e; mul_b = hx_e; end
      OP_HYHY: begin mul_a = hy_e; mul_b = hy_e; end
      OP_DXDX: begin mul_a = dx_e; mul_b = dx_e; end
      OP_DYDY: begin mul_a = dy_e; mul_b = dy_e; end
      OP_ACAC: begin mul_a = {18'd0, align_cos_r}; mul_b = {18'd0, align_cos_r}; end
      OP_DOT2: begin mul_a = dot_r; mul_b = dot_r; end
      OP_A2H2: begin mul_a = {3'd0, a2_r}; mul_b = {1'b0, h2_r}; end
      OP_SPIM: begin mul_a = sp_e; mul_b = {17'd0, inv_max_speed_r}; end
      OP_LOD2: begin mul_a = {1'b0, a2h2_r[31:0]}; mul_b = {1'b0, d2_r}; end
      OP_HID2: begin mul_a = {3'd0, a2h2_r[61:32]}; mul_b = {1'b0, d2_r}; end
      OP_HXC:  begin mul_a = hx_e; mul_b = cos_e; end
      OP_HYSN: begin mul_a = hy_e; mul_b = sn_e; end
      OP_HXSN: begin mul_a = hx_e; mul_b = sn_e; end
      OP_HYC:  begin mul_a = hy_e; mul_b = cos_e; end
      OP_MAD:  begin mul_a = {18'd0, m_r}; mul_b = {17'd0, span}; end
      default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product register and its op tag
  always_ff @(posedge clk) begin
    prod_r    <= mul_p;
    wb_step_r <= step_r;
  end

  // write back the previous step's product
  always_ff @(posedge clk) begin
    if (wb_vld_r) begin
      case (wb_step_r)
        OP_HXDX: dot_r  <= prod_r[32:0];
        OP_HYDY: dot_r  <= dot_r + prod_r[32:0];
        OP_HXDY: crs_r  <= prod_r[32:0];
        OP_HYDX: crs_r  <= crs_r - prod_r[32:0];
        OP_HXHX: h2_r   <= prod_r[31:0];
        OP_HYHY: h2_r   <= h2_r + prod_r[31:0];
        OP_DXDX: d2_r   <= prod_r[31:0];
        OP_DYDY: d2_r   <= d2_r + prod_r[31:0];
        OP_ACAC: a2_r   <= prod_r[29:0];
        OP_DOT2: dot2_r <= prod_r[62:0];
        OP_A2H2: a2h2_r <= prod_r[61:0];
        OP_SPIM: sprod_r <= prod_r[31:0];
        OP_LOD2: rhs_r  <= {30'd0, prod_r[63:0]};
        OP_HID2: rhs_r  <= rhs_r + {prod_r[61:0], 32'd0};
        OP_HXC:  nx_r   <= prod_r[32:0];
        OP_HYSN: nx_r   <= nx_r - prod_r[32:0];
        OP_HXSN: ny_r   <= prod_r[32:0];
        OP_HYC:  ny_r   <= ny_r + prod_r[32:0];
        OP_MAD:  q_r    <= prod_r[29:14];
        default: ;
      endcase
    end
  end

  // alignment decision and wheel level
  logic        dir_nz, head_z, aligned, turn;
  logic [31:0] sp_abs;
  logic [21:0] sp_sh;
  logic [14:0] mag_c, mag;
  logic        v_pos;

  always_comb begin
    dir_nz = (dx_r != 16'd0) | (dy_r != 16'd0);
    head_z = (hx_r == 16'd0) & (hy_r == 16'd0);
    if (head_z) begin
      aligned = (align_cos_r == 15'd0);
    end else if (dot_r[32]) begin
      aligned = 1'b0;
    end else begin
      aligned = ({3'd0, dot2_r, 28'd0} >= rhs_r);
    end
    turn   = dir_nz & ~aligned;
    sp_abs = sprod_r[31] ? 32'(-sprod_r) : 32'(sprod_r);
    sp_sh  = sp_abs[31:10];
    mag_c  = (sp_sh > {7'd0, Q14_ONE}) ? Q14_ONE : sp_sh[14:0];
    mag    = (mag_c < deadband_r) ? 15'd0 : mag_c;
    v_pos  = ~sprod_r[31] & (mag != 15'd0);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC && step_r == OP_HXSN) begin
      turn_r <= turn;
      if (!dir_nz) begin
        m_r         <= 15'd0;
        left_pos_r  <= 1'b0;
        right_pos_r <= 1'b0;
      end else if (turn) begin
        m_r         <= Q14_HALF;
        left_pos_r  <= crs_pos;
        right_pos_r <= ~crs_pos;
      end else begin
        m_r         <= mag;
        left_pos_r  <= v_pos;
        right_pos_r <= v_pos;
      end
    end
  end

  // final mapping: period, steps, action, rotated heading
  logic [16:0] per_raw;
  logic [15:0] per_drive, per_o;
  logic        wheel_on, moving, rotate;
  logic [10:0] spm_pos, spm_neg, lsteps, rsteps;
  logic signed [33:0] nx_rnd, ny_rnd;
  logic signed [19:0] nx_sh, ny_sh;
  logic [15:0] nx_sat, ny_sat;
  action_t     action;

  always_comb begin
    per_raw   = slow_ge ? ({1'b0, period_slow_r} - {1'b0, q_r})
                        : ({1'b0, period_slow_r} + {1'b0, q_r});
    per_drive = (per_raw < {1'b0, period_fast_r}) ? period_fast_r : per_raw[15:0];
    wheel_on  = (m_r >= deadband_r);
    per_o     = wheel_on ? per_drive : period_slow_r;
    spm_pos   = {1'b0, steps_per_move_r};
    spm_neg   = -spm_pos;
    lsteps    = wheel_on ? (left_pos_r ? spm_pos : spm_neg) : 11'd0;
    rsteps    = wheel_on ? (right_pos_r ? spm_pos : spm_neg) : 11'd0;
    moving    = wheel_on & (steps_per_move_r != 10'd0);
    rotate    = done_r & moving & turn_r;
    if (!done_r) begin
      action = ACT_HOLD;
    end else if (moving) begin
      action = ACT_MOVE;
    end else begin
      action = ACT_DISABLE;
    end
    // round half up to Q2.14, then saturate
    nx_rnd = {nx_r[32], nx_r} + 34'sd8192;
    ny_rnd = {ny_r[32], ny_r} + 34'sd8192;
    nx_sh  = nx_rnd[33:14];
    ny_sh  = ny_rnd[33:14];
    if (nx_sh > 20'sd32767) begin
      nx_sat = 16'h7FFF;
    end else if (nx_sh < -20'sd32768) begin
      nx_sat = 16'h8000;
    end else begin
      nx_sat = nx_sh[15:0];
    end
    if (ny_sh > 20'sd32767) begin
      ny_sat = 16'h7FFF;
    end else if (ny_sh < -20'sd32768) begin
      ny_sat = 16'h8000;
    end else begin
      ny_sat = ny_sh[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= OP_HXDX;
      wb_vld_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          wb_vld_r <= 1'b0;
          if (in_fire) begin
            state_r <= ST_CALC;
            step_r  <= OP_HXDX;
          end
        end
        ST_CALC: begin
          wb_vld_r <= 1'b1;
          if (step_r == OP_LAST) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        ST_DONE: begin
          wb_vld_r <= 1'b0;
          if (out_load) begin
            state_r <= ST_IDLE;
            step_r  <= OP_HXDX;
          end
        end
        default: begin
          state_r  <= ST_IDLE;
          wb_vld_r <= 1'b0;
        end
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dx_r   <= in_desired_x;
      dy_r   <= in_desired_y;
      sp_r   <= in_speed_cmd;
      done_r <= in_steps_done;
    end
  end

  // heading state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r <= RST_HEADING_X;
      hy_r <= RST_HEADING_Y;
    end else if (out_load && rotate) begin
      hx_r <= nx_sat;
      hy_r <= ny_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      action_r <= action;
      lsteps_r <= lsteps;
      rsteps_r <= rsteps;
      lper_r   <= per_o;
      rper_r   <= per_o;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = action_r;
  assign out_left_steps    = lsteps_r;
  assign out_right_steps   = rsteps_r;
  assign out_left_period   = lper_r;
  assign out_right_period  = rper_r;
  assign out_heading_x_out = hx_r;
  assign out_heading_y_out = hy_r;

`ifndef SYNTHESIS
  // a move always carries a nonzero left step count
  a_move_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_MOVE) |-> (out_left_steps != 11'd0))
    else $error("move beat with zero left steps");

  // a disable beat carries zero step counts
  a_disable_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_DISABLE) |->
      (out_left_steps == 11'd0 && out_right_steps == 11'd0))
    else $error("disable beat with nonzero steps");

  // unequal wheel counts are always a spin in place
  a_spin_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_left_steps != out_right_steps) |->
      (out_left_steps == 11'(-out_right_steps)))
    else $error("unequal wheel steps are not mirrored");

  // heading moves only when a result is loaded
  a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> ($stable(hx_r) && $stable(hy_r)))
    else $error("heading changed outside result load");

  // step counter stays inside the op table while computing
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (step_r <= OP_LAST))
    else $error("sequencer step out of range");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression of diff_drive_heading_stepper_ctrl
// frames are queued by a stimulus thread, driven by a clocked driver and
// predicted at acceptance by an in-bench copy of the steering math; a clocked
// monitor compares every result beat field by field against the oldest
// prediction; settings are reloaded over apb between phases while idle
// ----------------------------------------------------------------------------
module testbench
  import ddhsc_pkg::*;
();

  // one frame as offered on the input channel
  typedef struct packed {
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] speed;
    logic        done;
  } frame_cmd_t;

  // one predicted result beat
  typedef struct packed {
    action_t     action;
    logic [10:0] lsteps;
    logic [10:0] rsteps;
    logic [15:0] lper;
    logic [15:0] rper;
    logic [15:0] hx;
    logic [15:0] hy;
  } wheel_cmd_t;

  // shadow of the register file
  typedef struct {
    logic [15:0]        period_slow;
    logic [15:0]        period_fast;
    logic [9:0]         steps;
    logic [14:0]        deadband;
    logic [14:0]        align_cos;
    logic [15:0]        inv_max_speed;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
  } settings_t;

  localparam longint LEVEL_FULL = Q14_ONE;
  localparam longint LEVEL_TURN = Q14_HALF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_desired_x = '0;
  logic [15:0] in_desired_y = '0;
  logic [15:0] in_speed_cmd = '0;
  logic        in_steps_done = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_action;
  logic [10:0] out_left_steps;
  logic [10:0] out_right_steps;
  logic [15:0] out_left_period;
  logic [15:0] out_right_period;
  logic [15:0] out_heading_x_out;
  logic [15:0] out_heading_y_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_cmd_t         frame_q[$];
  wheel_cmd_t         predicted_q[$];
  settings_t          cfg;
  logic signed [15:0] head_x;
  logic signed [15:0] head_y;
  int                 mismatches = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  logic               quiet = 1'b0;
  logic               long_hold_req = 1'b0;
  logic               hold_seen = 1'b0;

  diff_drive_heading_stepper_ctrl u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_desired_x      (in_desired_x),
    .in_desired_y      (in_desired_y),
    .in_speed_cmd      (in_speed_cmd),
    .in_steps_done     (in_steps_done),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_left_steps    (out_left_steps),
    .out_right_steps   (out_right_steps),
    .out_left_period   (out_left_period),
    .out_right_period  (out_right_period),
    .out_heading_x_out (out_heading_x_out),
    .out_heading_y_out (out_heading_y_out),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic settings_t reset_settings();
    settings_t s;
    s.period_slow   = RST_PERIOD_SLOW;
    s.period_fast   = RST_PERIOD_FAST;
    s.steps         = RST_STEPS_PER_MOVE;
    s.deadband      = RST_DEADBAND;
    s.align_cos     = RST_ALIGN_COS;
    s.inv_max_speed = RST_INV_MAX_SPEED;
    s.rot_cos       = RST_ROT_COS;
    s.rot_sin       = RST_ROT_SIN;
    return s;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // velocity of one wheel to step count and stepper period
  function automatic void wheel_map(input longint v, output longint steps,
                                    output logic [15:0] period);
    longint m, slow, fast, span, p, db, spm;
    slow = cfg.period_slow;
    fast = cfg.period_fast;
    db   = cfg.deadband;
    spm  = cfg.steps;
    m    = (v < 0) ? -v : v;
    if (m < db) begin
      steps  = 0;
      period = cfg.period_slow;
    end else begin
      if (m > LEVEL_FULL) m = LEVEL_FULL;
      span = slow - fast;
      // truncation always moves toward period_slow
      if (span >= 0) p = slow - ((m * span) >>> 14);
      else p = slow + ((m * -span) >>> 14);
      if (p < fast) p = fast;
      period = p[15:0];
      steps  = (v > 0) ? spm : -spm;
    end
  endfunction

  // steering math for one accepted frame, advances the heading
  function automatic wheel_cmd_t steer_frame(frame_cmd_t f);
    longint x, y, sp, hx, hy, dot, crs, prod, mag, vl, vr, sl, sr, c, s, inv;
    longint unsigned h2, d2, a2, dsq;
    logic [127:0] lhs, rhs;
    logic aligned;
    logic [15:0] pl, pr;
    wheel_cmd_t r;
    x  = $signed(f.dx);
    y  = $signed(f.dy);
    sp = $signed(f.speed);
    hx = head_x;
    hy = head_y;
    vl = 0;
    vr = 0;
    if (x != 0 || y != 0) begin
      dot   = hx * x + hy * y;
      crs   = hx * y - hy * x;
      h2    = hx * hx + hy * hy;
      d2    = x * x + y * y;
      a2    = cfg.align_cos;
      a2    = a2 * a2;
      // cosine test done on squares, exact in 128 bits
      if (h2 == 0) aligned = (cfg.align_cos == 0);
      else if (dot < 0) aligned = 1'b0;
      else begin
        dsq     = dot * dot;
        lhs     = {64'd0, dsq} << 28;
        rhs     = {64'd0, a2 * h2} * {64'd0, d2};
        aligned = (lhs >= rhs);
      end
      if (!aligned) begin
        vl = (crs > 0) ? LEVEL_TURN : -LEVEL_TURN;
        vr = -vl;
      end else begin
        inv  = cfg.inv_max_speed;
        prod = sp * inv;
        mag  = ((prod < 0) ? -prod : prod) >>> 10;
        if (mag > LEVEL_FULL) mag = LEVEL_FULL;
        if (mag < longint'(cfg.deadband)) mag = 0;
        vl = (prod < 0) ? -mag : mag;
        vr = vl;
      end
    end
    wheel_map(vl, sl, pl);
    wheel_map(vr, sr, pr);
    r.action = ACT_HOLD;
    if (f.done) begin
      if (sl != 0 || sr != 0) begin
        r.action = ACT_MOVE;
        // unequal counts mean a turning move: rotate heading, round half up
        if (sl != sr) begin
          c = cfg.rot_cos;
          s = cfg.rot_sin;
          if (sl < sr) s = -s;
          head_x = clip16((hx * c - hy * s + 8192) >>> 14);
          head_y = clip16((hx * s + hy * c + 8192) >>> 14);
        end
      end else begin
        r.action = ACT_DISABLE;
      end
    end
    r.lsteps = sl[10:0];
    r.rsteps = sr[10:0];
    r.lper   = pl;
    r.rper   = pr;
    r.hx     = head_x;
    r.hy     = head_y;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // input driver: one beat per queued frame, random gaps between beats unless quiet
  always @(posedge clk) begin : drive_frames
    frame_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_q.push_back(steer_frame({in_desired_x, in_desired_y, in_speed_cmd,
                                           in_steps_done}));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (frame_q.size() != 0) begin
          nxt = frame_q.pop_front();
          in_valid      <= 1'b1;
          in_desired_x  <= nxt.dx;
          in_desired_y  <= nxt.dy;
          in_speed_cmd  <= nxt.speed;
          in_steps_done <= nxt.done;
          if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : watch_results
    wheel_cmd_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = predicted_q.pop_front();
          if (out_action !== want.action)
            report_mismatch($sformatf("action %0d want %0d", out_action, want.action));
          if (out_left_steps !== want.lsteps)
            report_mismatch($sformatf("left_steps %0d want %0d",
                                      $signed(out_left_steps), $signed(want.lsteps)));
          if (out_right_steps !== want.rsteps)
            report_mismatch($sformatf("right_steps %0d want %0d",
                                      $signed(out_right_steps), $signed(want.rsteps)));
          if (out_left_period !== want.lper)
            report_mismatch($sformatf("left_period %0d want %0d", out_left_period, want.lper));
          if (out_right_period !== want.rper)
            report_mismatch($sformatf("right_period %0d want %0d",
                                      out_right_period, want.rper));
          if (out_heading_x_out !== want.hx)
            report_mismatch($sformatf("heading_x %0d want %0d",
                                      $signed(out_heading_x_out), $signed(want.hx)));
          if (out_heading_y_out !== want.hy)
            report_mismatch($sformatf("heading_y %0d want %0d",
                                      $signed(out_heading_y_out), $signed(want.hy)));
        end
      end
      // long hold-off on request, else short random stall bursts
      hold_seen <= long_hold_req;
      if (long_hold_req && !hold_seen) begin
        stall_left <= 300;
        out_ready  <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(0, 18);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PERIOD_SLOW:    cfg.period_slow   = val;
      REG_PERIOD_FAST:    cfg.period_fast   = val;
      REG_STEPS_PER_MOVE: cfg.steps         = val[9:0];
      REG_DEADBAND:       cfg.deadband      = val[14:0];
      REG_ALIGN_COS:      cfg.align_cos     = val[14:0];
      REG_INV_MAX_SPEED:  cfg.inv_max_speed = val;
      REG_ROT_COS:        cfg.rot_cos       = val;
      REG_ROT_SIN:        cfg.rot_sin       = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input settings_t s);
    apb_write(REG_PERIOD_SLOW, s.period_slow);
    apb_write(REG_PERIOD_FAST, s.period_fast);
    apb_write(REG_STEPS_PER_MOVE, 16'(s.steps));
    apb_write(REG_DEADBAND, 16'(s.deadband));
    apb_write(REG_ALIGN_COS, 16'(s.align_cos));
    apb_write(REG_INV_MAX_SPEED, s.inv_max_speed);
    apb_write(REG_ROT_COS, s.rot_cos);
    apb_write(REG_ROT_SIN, s.rot_sin);
  endtask

  function automatic int pick_level(int lo, int hi, int typ_lo, int typ_hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  // random settings; rotation usually kept near unit length so the heading survives
  function automatic settings_t random_settings();
    settings_t s;
    longint sn, rem, root, b;
    s.period_slow   = 16'(pick_level(0, 65535, 20000, 60000));
    s.period_fast   = 16'(pick_level(0, 65535, 5000, 40000));
    s.steps         = 10'(pick_level(1, 1023, 1, 200));
    s.deadband      = 15'(pick_level(0, 16384, 0, 2000));
    s.align_cos     = 15'(pick_level(0, 16384, 12000, 16384));
    s.inv_max_speed = 16'(pick_level(0, 65535, 1000, 30000));
    if ($urandom_range(0, 7) == 0) begin
      s.rot_cos = 16'(int'($urandom_range(0, 2)) * 16384 - 16384);
      s.rot_sin = 16'(int'($urandom_range(0, 2)) * 16384 - 16384);
      if (s.rot_cos == 0 && s.rot_sin == 0) s.rot_cos = 16384;
    end else begin
      sn   = longint'($urandom_range(0, 32768)) - 16384;
      rem  = 268435456 - sn * sn;
      root = 0;
      for (b = 16384; b > 0; b = b >> 1)
        if ((root + b) * (root + b) <= rem) root = root + b;
      s.rot_sin = sn[15:0];
      s.rot_cos = ($urandom_range(0, 3) == 0) ? 16'(-root) : root[15:0];
    end
    return s;
  endfunction

  // keep the queue short so heading-aimed frames see a fresh heading
  task automatic send_frame(input logic [15:0] dx, input logic [15:0] dy,
                            input logic [15:0] sp, input logic done);
    while (frame_q.size() >= 2) @(posedge clk);
    frame_q.push_back({dx, dy, sp, done});
  endtask

  task automatic random_frames(input int n);
    int dxv, dyv, spv, sh, nz, hxv, hyv;
    repeat (n) begin
      while (frame_q.size() >= 2) @(posedge clk);
      hxv = head_x;
      hyv = head_y;
      case ($urandom_range(0, 9))
        0: begin
          dxv = 0;
          dyv = 0;
        end
        1, 2: begin
          dxv = $urandom_range(0, 65535);
          dyv = $urandom_range(0, 65535);
        end
        3: begin
          dxv = int'($urandom_range(0, 1024)) - 512;
          dyv = int'($urandom_range(0, 1024)) - 512;
        end
        default: begin
          // aimed along the current heading, with some noise
          sh = $urandom_range(0, 3);
          case ($urandom_range(0, 2))
            0: nz = 0;
            1: nz = 16;
            default: nz = 600;
          endcase
          dxv = (hxv >>> sh) + int'($urandom_range(0, 2 * nz)) - nz;
          dyv = (hyv >>> sh) + int'($urandom_range(0, 2 * nz)) - nz;
        end
      endcase
      case ($urandom_range(0, 3))
        0: spv = $urandom_range(0, 65535);
        1: spv = int'($urandom_range(0, 4096)) - 2048;
        2: spv = 0;
        default: spv = int'($urandom_range(0, 16384)) - 8192;
      endcase
      frame_q.push_back({16'(dxv), 16'(dyv), 16'(spv), ($urandom_range(0, 9) < 7)});
    end
  endtask

  // wait until every frame is sent and every result is back
  task automatic settle();
    while (frame_q.size() != 0 || in_valid || predicted_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    settings_t s;
    int phase;
    cfg    = reset_settings();
    head_x = RST_HEADING_X;
    head_y = RST_HEADING_Y;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed frames at reset settings, heading straight down
    send_frame(16'd0, 16'd0, 16'd4096, 1'b1);          // no direction, disable
    send_frame(16'd0, 16'd0, 16'd4096, 1'b0);          // no direction, hold
    send_frame(16'd0, -16'sd4096, 16'd4096, 1'b1);     // aligned, full speed
    send_frame(16'd0, -16'sd4096, 16'h8000, 1'b1);     // aligned, full reverse
    send_frame(16'd0, -16'sd4096, 16'd16, 1'b1);       // inside deadband
    send_frame(16'd0, -16'sd4096, 16'd1500, 1'b0);     // partial speed, not done
    send_frame(16'd0, -16'sd4096, 16'h7fff, 1'b1);
    send_frame(16'd4096, 16'd0, 16'd4096, 1'b1);       // misaligned, left turn
    send_frame(16'd4096, 16'd0, 16'd4096, 1'b0);       // misaligned, not done
    send_frame(-16'sd4096, 16'd0, 16'd4096, 1'b1);     // misaligned, right turn
    send_frame(16'd0, 16'd4096, 16'd4096, 1'b1);       // pointing behind
    send_frame(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_frame(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_frame(16'h7fff, 16'h8000, 16'd0, 1'b1);
    send_frame(16'h8000, 16'h7fff, 16'hffff, 1'b1);
    send_frame(16'd1, 16'd0, 16'd4096, 1'b1);
    send_frame(16'd0, 16'hffff, 16'd4096, 1'b1);
    send_frame(16'h7fff, 16'd0, 16'h8000, 1'b0);
    settle();

    // zero step count: every done frame disables
    apb_write(REG_STEPS_PER_MOVE, 16'd0);
    send_frame(16'(head_x), 16'(head_y), 16'd4096, 1'b1);
    send_frame(16'(-head_y), 16'(head_x), 16'd4096, 1'b1);
    send_frame(16'(-head_y), 16'(head_x), 16'd4096, 1'b0);
    settle();

    // all registers at their low extremes, then at their high extremes
    s = '{16'd0, 16'd0, 10'd1, 15'd0, 15'd0, 16'd0, -16'sd16384, -16'sd16384};
    load_settings(s);
    random_frames(60);
    settle();
    s = '{16'hffff, 16'hffff, 10'd1023, 15'd16384, 15'd16384, 16'hffff,
          16'sd16384, 16'sd16384};
    load_settings(s);
    random_frames(60);
    settle();

    // random settings phases
    for (phase = 0; phase < 10; phase++) begin
      load_settings(random_settings());
      if (phase == 2) long_hold_req <= 1'b1;
      quiet <= (phase == 5);
      random_frames(100);
      settle();
      long_hold_req <= 1'b0;
    end

    // closing stretch without idling
    quiet <= 1'b1;
    load_settings(reset_settings());
    random_frames(150);
    settle();

    // collapse the heading to zero with a null rotation, then probe it
    apb_write(REG_ROT_COS, 16'd0);
    apb_write(REG_ROT_SIN, 16'd0);
    send_frame(16'(-(head_y >>> 1)), 16'(head_x >>> 1), 16'd4096, 1'b1);
    send_frame(16'd4096, 16'd0, 16'd4096, 1'b1);
    send_frame(16'd0, -16'sd4096, 16'd4096, 1'b0);
    settle();
    apb_write(REG_ALIGN_COS, 16'd0);
    send_frame(16'd4096, 16'd0, 16'd4096, 1'b1);
    send_frame(16'd0, 16'd4096, 16'h8000, 1'b1);
    settle();

    if (mismatches == 0 && predicted_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
